>>> design/uxf_pkg.sv
`default_nettype none

package uxf_pkg;

    localparam int FIFO_DEPTH = 2048;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam int LEVEL_W    = 12;
    localparam int CTR_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 144;
    localparam int RES_W      = 140;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] XON_BYTE  = 8'h11;
    localparam logic [7:0] XOFF_BYTE = 8'h13;

    localparam logic [CFG_IDX_W-1:0] CFG_FLOW_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 2'd2;

    localparam logic [LEVEL_W-1:0] HIGH_THRESHOLD_RESET = 12'd1536;
    localparam logic [LEVEL_W-1:0] LOW_THRESHOLD_RESET  = 12'd768;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_PUSH  = 2'd1,
        OP_POP   = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        FLOW_NONE = 2'd0,
        FLOW_XOFF = 2'd1,
        FLOW_XON  = 2'd2
    } flow_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_FETCH = 1'b1
    } state_t;

    typedef struct packed {
        op_t        op;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [7:0] host_byte;
        logic       is_xoff;
        logic       is_xon;
    } req_t;

    // Declared from the top bit down, so line_tx_valid lands in bit 0.
    typedef struct packed {
        logic [CTR_W-1:0]   error_total;
        logic [CTR_W-1:0]   received_total;
        logic [CTR_W-1:0]   sent_total;
        logic [LEVEL_W-1:0] tx_space;
        logic [LEVEL_W-1:0] rx_level;
        logic [7:0]         host_data;
        logic               accepted;
        flow_t              flow_send;
        logic [7:0]         line_tx_byte;
        logic               line_tx_valid;
    } res_t;

endpackage

`default_nettype wire

>>> design/uxf_front.sv
`default_nettype none

module uxf_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [uxf_pkg::S_DATA_W-1:0]  s_axis_tdata,
    input  wire logic [1:0]                    s_axis_tuser,
    output logic                               req_valid,
    input  wire logic                          req_ready,
    output uxf_pkg::req_t                      req
);

    logic          valid_reg;
    logic          valid_next;
    uxf_pkg::req_t req_reg;
    uxf_pkg::req_t decoded;
    logic          s_fire;

    always_comb
    begin
        decoded.op        = uxf_pkg::op_t'(s_axis_tuser);
        decoded.rx_valid  = s_axis_tdata[0];
        decoded.rx_byte   = s_axis_tdata[8:1];
        decoded.host_byte = s_axis_tdata[16:9];
        decoded.is_xoff   = (s_axis_tdata[8:1] == uxf_pkg::XOFF_BYTE);
        decoded.is_xon    = (s_axis_tdata[8:1] == uxf_pkg::XON_BYTE);
    end

    assign s_axis_tready = !valid_reg || req_ready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign valid_next    = s_fire || (valid_reg && !req_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            req_reg <= decoded;
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

`default_nettype wire

>>> design/uxf_queue.sv
`default_nettype none

module uxf_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire uxf_pkg::req_t in_req,
    output logic               out_valid,
    input  wire logic          out_ready,
    output uxf_pkg::req_t      out_req
);

    uxf_pkg::req_t                 entry_reg [uxf_pkg::QUEUE_DEPTH];
    logic [uxf_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [uxf_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [uxf_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                          push;
    logic                          pop;

    assign in_ready  = (count_reg != uxf_pkg::QCNT_W'(uxf_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_req   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == uxf_pkg::QPTR_W'(uxf_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == uxf_pkg::QPTR_W'(uxf_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

`default_nettype wire

>>> design/uxf_back.sv
`default_nettype none

module uxf_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_ready,
    input  wire uxf_pkg::req_t                   req,
    input  wire logic                            cfg_valid,
    input  wire logic [uxf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [uxf_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output uxf_pkg::res_t                        res
);

    localparam int CMP_W = uxf_pkg::CTR_W;

    uxf_pkg::state_t               state_reg, state_next;

    logic [uxf_pkg::PTR_W-1:0]     tx_wr_ptr_reg, tx_wr_ptr_next;
    logic [uxf_pkg::PTR_W-1:0]     tx_rd_ptr_reg, tx_rd_ptr_next;
    logic [uxf_pkg::CNT_W-1:0]     tx_cnt_reg, tx_cnt_next;
    logic [uxf_pkg::PTR_W-1:0]     rx_wr_ptr_reg, rx_wr_ptr_next;
    logic [uxf_pkg::PTR_W-1:0]     rx_rd_ptr_reg, rx_rd_ptr_next;
    logic [uxf_pkg::CNT_W-1:0]     rx_cnt_reg, rx_cnt_next;
    logic                          remote_paused_reg, remote_paused_next;
    logic                          xoff_sent_reg, xoff_sent_next;
    logic [uxf_pkg::CTR_W-1:0]     sent_cnt_reg, sent_cnt_next;
    logic [uxf_pkg::CTR_W-1:0]     recv_cnt_reg, recv_cnt_next;
    logic [uxf_pkg::CTR_W-1:0]     err_cnt_reg, err_cnt_next;
    logic                          flow_en_reg, flow_en_next;
    logic [uxf_pkg::LEVEL_W-1:0]   high_thr_reg, high_thr_next;
    logic [uxf_pkg::LEVEL_W-1:0]   low_thr_reg, low_thr_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          sel_tx_reg, sel_tx_next;
    logic                          sel_rx_reg, sel_rx_next;
    uxf_pkg::res_t                 res_reg, res_next;

    logic [7:0]                    tx_mem [uxf_pkg::FIFO_DEPTH];
    logic [7:0]                    rx_mem [uxf_pkg::FIFO_DEPTH];
    logic [7:0]                    tx_rd_data_reg;
    logic [7:0]                    rx_rd_data_reg;
    logic                          tx_we, tx_re, rx_we, rx_re;

    logic                          start;
    logic                          flow_byte;
    logic                          rx_full;
    logic                          tx_full;
    logic                          store;
    logic                          send;
    logic [uxf_pkg::CNT_W-1:0]     rx_cnt_after;
    logic [uxf_pkg::CNT_W-1:0]     tx_cnt_after;

    function automatic logic [uxf_pkg::PTR_W-1:0] ptr_inc(input logic [uxf_pkg::PTR_W-1:0] p);
        ptr_inc = (p == uxf_pkg::PTR_W'(uxf_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign start     = (state_reg == uxf_pkg::ST_IDLE) && req_valid
                    && (!out_valid_reg || res_ready);
    assign req_ready = start;

    assign flow_byte = req.rx_valid && flow_en_reg && (req.is_xoff || req.is_xon);
    assign rx_full   = (rx_cnt_reg == uxf_pkg::CNT_W'(uxf_pkg::FIFO_DEPTH));
    assign tx_full   = (tx_cnt_reg == uxf_pkg::CNT_W'(uxf_pkg::FIFO_DEPTH));
    assign store     = req.rx_valid && !flow_byte && !rx_full;
    // Only a flow byte changes remote_paused_reg on a tick, and it also ends that tick,
    // so the old value is the right one to gate sending.
    assign send      = !flow_byte && !remote_paused_reg && (tx_cnt_reg != '0);

    always_comb
    begin
        state_next         = state_reg;
        tx_wr_ptr_next     = tx_wr_ptr_reg;
        tx_rd_ptr_next     = tx_rd_ptr_reg;
        tx_cnt_next        = tx_cnt_reg;
        rx_wr_ptr_next     = rx_wr_ptr_reg;
        rx_rd_ptr_next     = rx_rd_ptr_reg;
        rx_cnt_next        = rx_cnt_reg;
        remote_paused_next = remote_paused_reg;
        xoff_sent_next     = xoff_sent_reg;
        sent_cnt_next      = sent_cnt_reg;
        recv_cnt_next      = recv_cnt_reg;
        err_cnt_next       = err_cnt_reg;
        flow_en_next       = flow_en_reg;
        high_thr_next      = high_thr_reg;
        low_thr_next       = low_thr_reg;
        out_valid_next     = out_valid_reg && !res_ready;
        sel_tx_next        = sel_tx_reg;
        sel_rx_next        = sel_rx_reg;
        res_next           = res_reg;
        tx_we              = 1'b0;
        tx_re              = 1'b0;
        rx_we              = 1'b0;
        rx_re              = 1'b0;
        rx_cnt_after       = rx_cnt_reg;
        tx_cnt_after       = tx_cnt_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                uxf_pkg::CFG_FLOW_ENABLE:
                begin
                    flow_en_next = cfg_data[0];
                    if (!cfg_data[0])
                    begin
                        remote_paused_next = 1'b0;
                    end
                end
                uxf_pkg::CFG_HIGH_THRESHOLD: high_thr_next = cfg_data;
                uxf_pkg::CFG_LOW_THRESHOLD:  low_thr_next  = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            uxf_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    res_next       = '0;
                    sel_tx_next    = 1'b0;
                    sel_rx_next    = 1'b0;
                    out_valid_next = 1'b0;
                    state_next     = uxf_pkg::ST_FETCH;
                    unique case (req.op)
                        uxf_pkg::OP_TICK:
                        begin
                            if (req.rx_valid && flow_en_reg && req.is_xoff)
                            begin
                                remote_paused_next = 1'b1;
                            end
                            else if (req.rx_valid && flow_en_reg && req.is_xon)
                            begin
                                remote_paused_next = 1'b0;
                            end
                            else if (req.rx_valid && rx_full)
                            begin
                                err_cnt_next = err_cnt_reg + 1'b1;
                            end
                            if (store)
                            begin
                                rx_we          = 1'b1;
                                rx_wr_ptr_next = ptr_inc(rx_wr_ptr_reg);
                                rx_cnt_after   = rx_cnt_reg + 1'b1;
                                recv_cnt_next  = recv_cnt_reg + 1'b1;
                            end
                            rx_cnt_next = rx_cnt_after;
                            if (send)
                            begin
                                tx_re          = 1'b1;
                                tx_rd_ptr_next = ptr_inc(tx_rd_ptr_reg);
                                tx_cnt_after   = tx_cnt_reg - 1'b1;
                                sent_cnt_next  = sent_cnt_reg + 1'b1;
                                sel_tx_next    = 1'b1;
                                res_next.line_tx_valid = 1'b1;
                            end
                            tx_cnt_next = tx_cnt_after;
                            if (!flow_byte && flow_en_reg)
                            begin
                                if ((CMP_W'(rx_cnt_after) > CMP_W'(high_thr_reg))
                                    && !xoff_sent_reg)
                                begin
                                    xoff_sent_next     = 1'b1;
                                    res_next.flow_send = uxf_pkg::FLOW_XOFF;
                                end
                                else if ((CMP_W'(rx_cnt_after) < CMP_W'(low_thr_reg))
                                         && xoff_sent_reg)
                                begin
                                    xoff_sent_next     = 1'b0;
                                    res_next.flow_send = uxf_pkg::FLOW_XON;
                                end
                            end
                            res_next.sent_total     = sent_cnt_next;
                            res_next.received_total = recv_cnt_next;
                            res_next.error_total    = err_cnt_next;
                        end
                        uxf_pkg::OP_PUSH:
                        begin
                            if (!tx_full)
                            begin
                                tx_we             = 1'b1;
                                tx_wr_ptr_next    = ptr_inc(tx_wr_ptr_reg);
                                tx_cnt_after      = tx_cnt_reg + 1'b1;
                                res_next.accepted = 1'b1;
                            end
                            tx_cnt_next             = tx_cnt_after;
                            res_next.sent_total     = sent_cnt_reg;
                            res_next.received_total = recv_cnt_reg;
                            res_next.error_total    = err_cnt_reg;
                        end
                        uxf_pkg::OP_POP:
                        begin
                            if (rx_cnt_reg != '0)
                            begin
                                rx_re             = 1'b1;
                                rx_rd_ptr_next    = ptr_inc(rx_rd_ptr_reg);
                                rx_cnt_after      = rx_cnt_reg - 1'b1;
                                sel_rx_next       = 1'b1;
                                res_next.accepted = 1'b1;
                            end
                            rx_cnt_next             = rx_cnt_after;
                            res_next.sent_total     = sent_cnt_reg;
                            res_next.received_total = recv_cnt_reg;
                            res_next.error_total    = err_cnt_reg;
                        end
                        uxf_pkg::OP_CLEAR:
                        begin
                            tx_wr_ptr_next     = '0;
                            tx_rd_ptr_next     = '0;
                            tx_cnt_next        = '0;
                            rx_wr_ptr_next     = '0;
                            rx_rd_ptr_next     = '0;
                            rx_cnt_next        = '0;
                            remote_paused_next = 1'b0;
                            xoff_sent_next     = 1'b0;
                            sent_cnt_next      = '0;
                            recv_cnt_next      = '0;
                            err_cnt_next       = '0;
                            rx_cnt_after       = '0;
                            tx_cnt_after       = '0;
                        end
                        default: ;
                    endcase
                    res_next.rx_level = uxf_pkg::LEVEL_W'(rx_cnt_after);
                    res_next.tx_space = uxf_pkg::LEVEL_W'(
                        uxf_pkg::CNT_W'(uxf_pkg::FIFO_DEPTH) - tx_cnt_after);
                end
            end
            uxf_pkg::ST_FETCH:
            begin
                // Read data from the FIFO memories arrives in the cycle after the address.
                if (sel_tx_reg)
                begin
                    res_next.line_tx_byte = tx_rd_data_reg;
                end
                if (sel_rx_reg)
                begin
                    res_next.host_data = rx_rd_data_reg;
                end
                out_valid_next = 1'b1;
                state_next     = uxf_pkg::ST_IDLE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= uxf_pkg::ST_IDLE;
            tx_wr_ptr_reg     <= '0;
            tx_rd_ptr_reg     <= '0;
            tx_cnt_reg        <= '0;
            rx_wr_ptr_reg     <= '0;
            rx_rd_ptr_reg     <= '0;
            rx_cnt_reg        <= '0;
            remote_paused_reg <= 1'b0;
            xoff_sent_reg     <= 1'b0;
            sent_cnt_reg      <= '0;
            recv_cnt_reg      <= '0;
            err_cnt_reg       <= '0;
            flow_en_reg       <= 1'b1;
            high_thr_reg      <= uxf_pkg::HIGH_THRESHOLD_RESET;
            low_thr_reg       <= uxf_pkg::LOW_THRESHOLD_RESET;
            out_valid_reg     <= 1'b0;
            sel_tx_reg        <= 1'b0;
            sel_rx_reg        <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            tx_wr_ptr_reg     <= tx_wr_ptr_next;
            tx_rd_ptr_reg     <= tx_rd_ptr_next;
            tx_cnt_reg        <= tx_cnt_next;
            rx_wr_ptr_reg     <= rx_wr_ptr_next;
            rx_rd_ptr_reg     <= rx_rd_ptr_next;
            rx_cnt_reg        <= rx_cnt_next;
            remote_paused_reg <= remote_paused_next;
            xoff_sent_reg     <= xoff_sent_next;
            sent_cnt_reg      <= sent_cnt_next;
            recv_cnt_reg      <= recv_cnt_next;
            err_cnt_reg       <= err_cnt_next;
            flow_en_reg       <= flow_en_next;
            high_thr_reg      <= high_thr_next;
            low_thr_reg       <= low_thr_next;
            out_valid_reg     <= out_valid_next;
            sel_tx_reg        <= sel_tx_next;
            sel_rx_reg        <= sel_rx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (tx_we)
        begin
            tx_mem[tx_wr_ptr_reg] <= req.host_byte;
        end
        if (tx_re)
        begin
            tx_rd_data_reg <= tx_mem[tx_rd_ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_we)
        begin
            rx_mem[rx_wr_ptr_reg] <= req.rx_byte;
        end
        if (rx_re)
        begin
            rx_rd_data_reg <= rx_mem[rx_rd_ptr_reg];
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

>>> design/uart_bridge_xon_xoff_fifos_top.sv
// UART bridge with 2048-byte transmit and receive FIFOs and XON/XOFF flow control.
// Requests enter on the s_axis channel: tuser carries the operation (tick, host push,
// host pop, clear), tdata the line receive byte with its valid flag and the host byte.
// Every request gives exactly one result on the m_axis channel, in request order,
// with the sent data byte, the flow byte code, the host pop data, the receive
// FIFO level, the transmit FIFO free space and the three 32-bit counters.
// Configuration writes (flow enable, high and low thresholds) use the cfg channel,
// which is always ready; write it only while no request is in flight.
// A request passes an input register and a two-entry queue, then the execution
// unit handles it in ST_IDLE, which updates the FIFO state and addresses the FIFO
// memories, and then in ST_FETCH, which captures the memory read data into the
// output register. The execution unit takes no new request until the one before
// it has left ST_FETCH and its result has been taken or is being taken.
// A result waits in the output register while m_axis_tready is low; up to three
// further requests are taken meanwhile, then s_axis_tready drops.
// Reset empties both FIFOs, zeroes the counters and flags, enables flow control
// and loads thresholds 1536 and 768. FIFO contents are not cleared.
`default_nettype none

module uart_bridge_xon_xoff_fifos_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // line_rx_valid [0], line_rx_byte [8:1], host_byte [16:9], zero [23:17]
    input  wire logic [uxf_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // operation [1:0]
    input  wire logic [1:0]                      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // line_tx_valid [0], line_tx_byte [8:1], flow_send [10:9], accepted [11],
    // host_data [19:12], rx_level [31:20], tx_space [43:32], sent_total [75:44],
    // received_total [107:76], error_total [139:108], zero [143:140]
    output logic [uxf_pkg::M_DATA_W-1:0]         m_axis_tdata,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [uxf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [uxf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic          front_valid;
    logic          front_ready;
    uxf_pkg::req_t front_req;
    logic          queue_valid;
    logic          queue_ready;
    uxf_pkg::req_t queue_req;
    uxf_pkg::res_t result;

    assign cfg_ready = 1'b1;

    uxf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .req_valid     (front_valid),
        .req_ready     (front_ready),
        .req           (front_req)
    );

    uxf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_req    (front_req),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_req   (queue_req)
    );

    uxf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (queue_valid),
        .req_ready (queue_ready),
        .req       (queue_req),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (result)
    );

    assign m_axis_tdata = {{(uxf_pkg::M_DATA_W - uxf_pkg::RES_W){1'b0}}, result};

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import uxf_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 8;
    localparam int OPENING_ROWS = 20;
    localparam int MIX_PHASES = 6;
    localparam int MIX_ITEMS = 180;

    typedef enum int {
        PACE_FULL,
        PACE_SENDER_IDLE,
        PACE_RECEIVER_STALL,
        PACE_BOTH
    } pace_t;

    // Opening rows: a request plus, where chk is set, the expected accepted flag,
    // flow code, receive FIFO level and transmit FIFO free space.
    typedef struct packed {
        op_t               op;
        logic              rxv;
        logic [7:0]        rxb;
        logic [7:0]        hb;
        logic              chk;
        logic              acc;
        flow_t             flow;
        logic [LEVEL_W-1:0] lvl;
        logic [LEVEL_W-1:0] space;
    } glance_row_t;

    typedef struct packed {
        logic       flow;
        logic [11:0] hi;
        logic [11:0] lo;
        pace_t      pace;
    } mix_phase_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Bridge predictor state.
    logic [7:0]       txq_mem [FIFO_DEPTH];
    logic [7:0]       rxq_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] txq_wr, txq_rd, rxq_wr, rxq_rd;
    int               txq_fill, rxq_fill;
    logic             far_paused, xoff_issued, flow_on;
    int               xoff_level, xon_level;
    logic [31:0]      bytes_sent, bytes_stored, bytes_dropped;

    res_t pending_results [$];
    int   send_idle_pct, stall_pct;
    int   n_errors, n_requests, n_checked, n_xoff, n_xon, n_drops, n_refused;
    int   cycle_count = 0;

    glance_row_t opening_rows [OPENING_ROWS];
    mix_phase_t  mix_phases [MIX_PHASES];

    uart_bridge_xon_xoff_fifos_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        m_axis_tready <= rst_n && ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic clear_bridge();
        txq_wr = '0;
        txq_rd = '0;
        rxq_wr = '0;
        rxq_rd = '0;
        txq_fill = 0;
        rxq_fill = 0;
        far_paused = 1'b0;
        xoff_issued = 1'b0;
        bytes_sent = '0;
        bytes_stored = '0;
        bytes_dropped = '0;
    endtask

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx, input int value);
        case (idx)
            CFG_FLOW_ENABLE:
            begin
                flow_on = value[0];
                if (!flow_on)
                    far_paused = 1'b0;
            end
            CFG_HIGH_THRESHOLD: xoff_level = value & 12'hFFF;
            CFG_LOW_THRESHOLD:  xon_level = value & 12'hFFF;
            default: ;
        endcase
    endtask

    task automatic bridge_step(input op_t op, input logic rxv, input logic [7:0] rxb,
                               input logic [7:0] hb, output res_t r);
        logic ended;
        r = '0;
        ended = 1'b0;
        case (op)
            OP_TICK:
            begin
                if (rxv)
                begin
                    if (flow_on && rxb == XOFF_BYTE)
                    begin
                        far_paused = 1'b1;
                        ended = 1'b1;
                    end
                    else if (flow_on && rxb == XON_BYTE)
                    begin
                        far_paused = 1'b0;
                        ended = 1'b1;
                    end
                    else if (rxq_fill >= FIFO_DEPTH)
                    begin
                        bytes_dropped = bytes_dropped + 1;
                        n_drops++;
                    end
                    else
                    begin
                        rxq_mem[rxq_wr] = rxb;
                        rxq_wr = rxq_wr + 1'b1;
                        rxq_fill++;
                        bytes_stored = bytes_stored + 1;
                    end
                end
                if (!ended)
                begin
                    if (!far_paused && txq_fill > 0)
                    begin
                        r.line_tx_byte = txq_mem[txq_rd];
                        r.line_tx_valid = 1'b1;
                        txq_rd = txq_rd + 1'b1;
                        txq_fill--;
                        bytes_sent = bytes_sent + 1;
                    end
                    if (flow_on)
                    begin
                        if (rxq_fill > xoff_level && !xoff_issued)
                        begin
                            xoff_issued = 1'b1;
                            r.flow_send = FLOW_XOFF;
                            n_xoff++;
                        end
                        else if (rxq_fill < xon_level && xoff_issued)
                        begin
                            xoff_issued = 1'b0;
                            r.flow_send = FLOW_XON;
                            n_xon++;
                        end
                    end
                end
            end
            OP_PUSH:
            begin
                if (txq_fill < FIFO_DEPTH)
                begin
                    txq_mem[txq_wr] = hb;
                    txq_wr = txq_wr + 1'b1;
                    txq_fill++;
                    r.accepted = 1'b1;
                end
                else
                    n_refused++;
            end
            OP_POP:
            begin
                if (rxq_fill > 0)
                begin
                    r.host_data = rxq_mem[rxq_rd];
                    rxq_rd = rxq_rd + 1'b1;
                    rxq_fill--;
                    r.accepted = 1'b1;
                end
                else
                    n_refused++;
            end
            default: clear_bridge();
        endcase
        r.rx_level = LEVEL_W'(rxq_fill);
        r.tx_space = LEVEL_W'(FIFO_DEPTH - txq_fill);
        r.sent_total = bytes_sent;
        r.received_total = bytes_stored;
        r.error_total = bytes_dropped;
    endtask

    task automatic set_pace(input pace_t p);
        case (p)
            PACE_FULL:           begin send_idle_pct = 0;  stall_pct = 0;  end
            PACE_SENDER_IDLE:    begin send_idle_pct = 51; stall_pct = 0;  end
            PACE_RECEIVER_STALL: begin send_idle_pct = 0;  stall_pct = 51; end
            default:             begin send_idle_pct = 10; stall_pct = 10; end
        endcase
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance with
    // tvalid still high, so back-to-back requests never toggle it within a step.
    task automatic send(input op_t op, input logic rxv, input logic [7:0] rxb,
                        input logic [7:0] hb);
        res_t want;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {7'b0, hb, rxb, rxv};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bridge_step(op, rxv, rxb, hb, want);
        pending_results.push_back(want);
        n_requests++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_register(idx, value);
        @(negedge clk);
    endtask

    task automatic program_regs(input logic flow, input int hi, input int lo);
        wait_drained();
        write_reg(CFG_FLOW_ENABLE, flow);
        write_reg(CFG_HIGH_THRESHOLD, hi);
        write_reg(CFG_LOW_THRESHOLD, lo);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_request();
        int   pick;
        op_t  op;
        logic [7:0] rxb;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            op = OP_TICK;
        else if (pick < 72)
            op = OP_PUSH;
        else if (pick < 98)
            op = OP_POP;
        else
            op = OP_CLEAR;
        rxb = 8'($urandom);
        // Flow bytes show up often enough to toggle the pause flag.
        if ($urandom_range(0, 3) == 0)
            rxb = $urandom_range(0, 1) ? XON_BYTE : XOFF_BYTE;
        send(op, $urandom_range(0, 3) != 0, rxb, 8'($urandom));
    endtask

    function automatic void compare_field(input string what, input longint unsigned want,
                                          input longint unsigned seen);
        if (want !== seen)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, seen);
            n_errors++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        res_t want;
        res_t seen;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen = m_axis_tdata[RES_W-1:0];
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         m_axis_tdata);
                n_errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                n_checked++;
                compare_field("line_tx_valid", want.line_tx_valid, seen.line_tx_valid);
                compare_field("line_tx_byte", want.line_tx_byte, seen.line_tx_byte);
                compare_field("flow_send", want.flow_send, seen.flow_send);
                compare_field("accepted", want.accepted, seen.accepted);
                compare_field("host_data", want.host_data, seen.host_data);
                compare_field("rx_level", want.rx_level, seen.rx_level);
                compare_field("tx_space", want.tx_space, seen.tx_space);
                compare_field("sent_total", want.sent_total, seen.sent_total);
                compare_field("received_total", want.received_total, seen.received_total);
                compare_field("error_total", want.error_total, seen.error_total);
                compare_field("tdata padding", 0, m_axis_tdata[M_DATA_W-1:RES_W]);
            end
        end
    end

    initial
    begin
        int   last;
        logic [7:0] b;

        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        n_errors = 0;
        n_requests = 0;
        n_checked = 0;
        n_xoff = 0;
        n_xon = 0;
        n_drops = 0;
        n_refused = 0;
        clear_bridge();
        flow_on = 1'b1;
        xoff_level = HIGH_THRESHOLD_RESET;
        xon_level = LOW_THRESHOLD_RESET;
        set_pace(PACE_FULL);

        opening_rows = '{
            '{OP_POP,   1'b0, 8'h00,     8'h00, 1'b1, 1'b0, FLOW_NONE, 12'd0, 12'd2048},
            '{OP_TICK,  1'b0, 8'h00,     8'h00, 1'b1, 1'b0, FLOW_NONE, 12'd0, 12'd2048},
            '{OP_PUSH,  1'b0, 8'h00,     8'h00, 1'b1, 1'b1, FLOW_NONE, 12'd0, 12'd2047},
            '{OP_PUSH,  1'b1, 8'hFF,     8'hFF, 1'b1, 1'b1, FLOW_NONE, 12'd0, 12'd2046},
            '{OP_PUSH,  1'b0, 8'h00,     8'hA5, 1'b0, 1'b0, FLOW_NONE, 12'd0, 12'd0},
            '{OP_TICK,  1'b1, 8'hFF,     8'h00, 1'b1, 1'b0, FLOW_NONE, 12'd1, 12'd2046},
            '{OP_TICK,  1'b1, XOFF_BYTE, 8'h00, 1'b1, 1'b0, FLOW_NONE, 12'd1, 12'd2046},
            '{OP_TICK,  1'b1, 8'h00,     8'h00, 1'b1, 1'b0, FLOW_NONE, 12'd2, 12'd2046},
            '{OP_TICK,  1'b0, 8'h00,     8'h00, 1'b1, 1'b0, FLOW_NONE, 12'd2, 12'd2046},
            '{OP_TICK,  1'b1, XON_BYTE,  8'h00, 1'b1, 1'b0, FLOW_NONE, 12'd2, 12'd2046},
            '{OP_TICK,  1'b1, 8'h5A,     8'h00, 1'b0, 1'b0, FLOW_NONE, 12'd0, 12'd0},
            '{OP_POP,   1'b0, 8'h00,     8'h00, 1'b0, 1'b0, FLOW_NONE, 12'd0, 12'd0},
            '{OP_POP,   1'b0, 8'h00,     8'h00, 1'b0, 1'b0, FLOW_NONE, 12'd0, 12'd0},
            '{OP_POP,   1'b0, 8'h00,     8'h00, 1'b0, 1'b0, FLOW_NONE, 12'd0, 12'd0},
            '{OP_POP,   1'b0, 8'h00,     8'h00, 1'b1, 1'b0, FLOW_NONE, 12'd0, 12'd2047},
            '{OP_PUSH,  1'b0, 8'h00,     XON_BYTE, 1'b0, 1'b0, FLOW_NONE, 12'd0, 12'd0},
            '{OP_TICK,  1'b0, XOFF_BYTE, 8'h00, 1'b0, 1'b0, FLOW_NONE, 12'd0, 12'd0},
            '{OP_CLEAR, 1'b1, 8'hFF,     8'hFF, 1'b1, 1'b0, FLOW_NONE, 12'd0, 12'd2048},
            '{OP_TICK,  1'b1, XOFF_BYTE, 8'h00, 1'b1, 1'b0, FLOW_NONE, 12'd0, 12'd2048},
            '{OP_TICK,  1'b1, 8'h3C,     8'h00, 1'b1, 1'b0, FLOW_NONE, 12'd1, 12'd2048}
        };

        mix_phases = '{
            '{1'b1, 12'd4,    12'd2,    PACE_FULL},
            '{1'b1, 12'd0,    12'd2048, PACE_SENDER_IDLE},
            '{1'b0, 12'd8,    12'd3,    PACE_RECEIVER_STALL},
            '{1'b1, 12'd2048, 12'd0,    PACE_BOTH},
            '{1'b1, 12'd12,   12'd6,    PACE_SENDER_IDLE},
            '{1'b0, 12'd2048, 12'd2048, PACE_FULL}
        };

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Opening rows run on the reset register values.
        foreach (opening_rows[i])
        begin
            send(opening_rows[i].op, opening_rows[i].rxv, opening_rows[i].rxb,
                 opening_rows[i].hb);
            if (opening_rows[i].chk)
            begin
                last = pending_results.size() - 1;
                pending_results[last].accepted = opening_rows[i].acc;
                pending_results[last].flow_send = opening_rows[i].flow;
                pending_results[last].rx_level = opening_rows[i].lvl;
                pending_results[last].tx_space = opening_rows[i].space;
            end
        end

        foreach (mix_phases[p])
        begin
            program_regs(mix_phases[p].flow, mix_phases[p].hi, mix_phases[p].lo);
            set_pace(mix_phases[p].pace);
            for (int k = 0; k < MIX_ITEMS; k++)
            begin
                random_request();
                // Halfway through, hold off until every result is back.
                if (k == MIX_ITEMS / 2)
                    wait_drained();
            end
        end

        // Raise the receive level past the high threshold so XOFF goes out.
        program_regs(1'b1, 3, 2);
        set_pace(PACE_RECEIVER_STALL);
        send(OP_CLEAR, 1'($urandom), 8'($urandom), 8'($urandom));
        repeat (3) send(OP_PUSH, 1'($urandom), 8'($urandom), 8'($urandom));
        repeat (5)
        begin
            do
                b = 8'($urandom);
            while (b == XON_BYTE || b == XOFF_BYTE);
            send(OP_TICK, 1'b1, b, 8'($urandom));
        end

        // With flow control off, a flow byte is plain data; the XOFF already sent
        // is remembered, so XON follows once it is back on.
        program_regs(1'b0, 3, 2);
        set_pace(PACE_BOTH);
        send(OP_TICK, 1'b1, XOFF_BYTE, 8'($urandom));
        repeat (5) send(OP_POP, 1'($urandom), 8'($urandom), 8'($urandom));
        repeat (3) send(OP_TICK, 1'b0, 8'($urandom), 8'($urandom));
        program_regs(1'b1, 3, 2);
        repeat (3) send(OP_TICK, 1'b0, 8'($urandom), 8'($urandom));
        repeat (40) random_request();
        send(OP_CLEAR, 1'($urandom), 8'($urandom), 8'($urandom));

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests and %0d checked results across %0d register settings.",
                 n_requests, n_checked, MIX_PHASES + 4);
        $display("Saw %0d XOFF and %0d XON sent, %0d line bytes dropped,",
                 n_xoff, n_xon, n_drops);
        $display("and %0d pushes or pops refused.", n_refused);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
